/* src/chbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types and constants for the cassette half-cycle byte decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

  localparam int unsigned StampW = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 3;
  localparam int unsigned CmpW   = 10;

  // gap windows, bounds exclusive
  localparam logic [CmpW-1:0] HdrLo   = CmpW'(650);
  localparam logic [CmpW-1:0] HdrHi   = CmpW'(660);
  localparam logic [CmpW-1:0] Sync1Lo = CmpW'(190);
  localparam logic [CmpW-1:0] Sync1Hi = CmpW'(210);
  localparam logic [CmpW-1:0] ZeroLo  = CmpW'(245);
  localparam logic [CmpW-1:0] ZeroHi  = CmpW'(255);
  localparam logic [CmpW-1:0] OneLo   = CmpW'(495);
  localparam logic [CmpW-1:0] OneHi   = CmpW'(505);

  localparam logic [ByteW-1:0] MsbMask = 8'h80;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_DATA  = 2'd2
  } phase_e;

  typedef enum logic {
    CFG_TAPE_LOADED   = 1'b0,
    CFG_WRITE_ALLOWED = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    EV_BYTE   = 1'b0,
    EV_REWIND = 1'b1
  } event_kind_e;

  typedef struct packed {
    logic             event_kind;
    logic [ByteW-1:0] data_byte;
  } result_t;

endpackage
`default_nettype wire

/* src/chbd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chbd channel interfaces
// Valid/ready channels for toggle events, decoded results and register writes.
// ----------------------------------------------------------------------------
interface chbd_event_if;
  logic                        valid;
  logic                        ready;
  logic [chbd_pkg::StampW-1:0] cycle_stamp;
  modport source (output valid, output cycle_stamp, input ready);
  modport sink   (input valid, input cycle_stamp, output ready);
endinterface

interface chbd_result_if;
  logic                       valid;
  logic                       ready;
  logic                       event_kind;
  logic [chbd_pkg::ByteW-1:0] data_byte;
  modport source (output valid, output event_kind, output data_byte, input ready);
  modport sink   (input valid, input event_kind, input data_byte, output ready);
endinterface

interface chbd_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/chbd_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chbd_core
// Input register, gap classification and tape state; one event per cycle unless the result buffer is full.
// ----------------------------------------------------------------------------
module chbd_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [chbd_pkg::StampW-1:0] in_stamp_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_index_i,
  input  wire logic                        cfg_data_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output chbd_pkg::result_t                push_data_o
);

  logic                        stg_valid_q, stg_valid_d;
  logic [chbd_pkg::StampW-1:0] stg_stamp_q;
  logic                        advance;

  logic                          tape_loaded_q, write_allowed_q;
  logic [chbd_pkg::StampW-1:0]   last_q, last_d;
  chbd_pkg::phase_e              phase_q, phase_d;
  logic                          first_q, first_d;
  logic                          toggle_q, toggle_d;
  logic [chbd_pkg::PosW-1:0]     pos_q, pos_d;
  logic [chbd_pkg::ByteW-1:0]    acc_q, acc_d;

  logic [chbd_pkg::StampW-1:0] gap;
  logic [chbd_pkg::CmpW-1:0]   gap_lo;
  logic                        gap_small;
  logic                        is_hdr, is_sync1, is_zero, is_one;
  logic                        enabled, rewind, byte_done;
  logic [chbd_pkg::ByteW-1:0]  acc_or;

  assign advance    = stg_valid_q && push_ready_i;
  assign in_ready_o = !stg_valid_q || push_ready_i;
  assign stg_valid_d = in_ready_o ? in_valid_i : stg_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_stamp_q <= in_stamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_loaded_q   <= 1'b0;
      write_allowed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (chbd_pkg::cfg_reg_e'(cfg_index_i))
        chbd_pkg::CFG_TAPE_LOADED:   tape_loaded_q   <= cfg_data_i;
        chbd_pkg::CFG_WRITE_ALLOWED: write_allowed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign gap       = stg_stamp_q - last_q;
  assign gap_small = (gap[chbd_pkg::StampW-1:chbd_pkg::CmpW] == '0);
  assign gap_lo    = gap[chbd_pkg::CmpW-1:0];
  assign is_hdr    = gap_small && gap_lo > chbd_pkg::HdrLo && gap_lo < chbd_pkg::HdrHi;
  assign is_sync1  = gap_small && gap_lo > chbd_pkg::Sync1Lo && gap_lo < chbd_pkg::Sync1Hi;
  assign is_zero   = gap_small && gap_lo > chbd_pkg::ZeroLo && gap_lo < chbd_pkg::ZeroHi;
  assign is_one    = gap_small && gap_lo > chbd_pkg::OneLo && gap_lo < chbd_pkg::OneHi;
  assign enabled   = advance && tape_loaded_q && write_allowed_q;
  assign acc_or    = acc_q | (chbd_pkg::MsbMask >> pos_q);

  always_comb begin
    last_d    = last_q;
    phase_d   = phase_q;
    first_d   = first_q;
    toggle_d  = toggle_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    rewind    = 1'b0;
    byte_done = 1'b0;
    push_data_o.event_kind = chbd_pkg::EV_REWIND;
    push_data_o.data_byte  = '0;
    if (enabled) begin
      last_d  = stg_stamp_q;
      first_d = 1'b0;
      rewind  = first_q;
      if (is_hdr) begin
        phase_d = chbd_pkg::PH_IDLE;
      end else begin
        case (phase_q)
          chbd_pkg::PH_IDLE: begin
            if (is_sync1) phase_d = chbd_pkg::PH_SYNC2;
          end
          chbd_pkg::PH_SYNC2: begin
            if (is_zero) begin
              phase_d  = chbd_pkg::PH_DATA;
              toggle_d = 1'b1;
              pos_d    = '0;
              acc_d    = '0;
              rewind   = 1'b1;
            end
          end
          chbd_pkg::PH_DATA: begin
            if (!is_zero && !is_one) begin
              phase_d = chbd_pkg::PH_IDLE;
            end else begin
              toggle_d = !toggle_q;
              if (!toggle_q) begin
                if (is_one) acc_d = acc_or;
                pos_d = pos_q + 1'b1;
                if (pos_q == '1) begin
                  byte_done = 1'b1;
                  push_data_o.data_byte = acc_d;
                  acc_d = '0;
                end
              end
            end
          end
          default: ;
        endcase
      end
      if (byte_done) begin
        push_data_o.event_kind = chbd_pkg::EV_BYTE;
      end
    end
  end

  assign push_valid_o = byte_done || rewind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      phase_q  <= chbd_pkg::PH_SYNC2;
      first_q  <= 1'b1;
      toggle_q <= 1'b0;
      pos_q    <= '0;
      acc_q    <= '0;
    end else begin
      last_q   <= last_d;
      phase_q  <= phase_d;
      first_q  <= first_d;
      toggle_q <= toggle_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
    end
  end

endmodule
`default_nettype wire

/* src/chbd_out_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chbd_out_buf
// Two-entry result buffer that decouples the decoder from a stalled sink.
// ----------------------------------------------------------------------------
module chbd_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire chbd_pkg::result_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output chbd_pkg::result_t      pop_data_o
);

  chbd_pkg::result_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

/* src/cassette_half_cycle_byte_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cassette_half_cycle_byte_decoder
// Path: an accepted event beat is registered in the input stage, and its result in the result buffer.
// Throughput: one event beat per cycle while the result buffer is not full; its two entries absorb stalls.
// The 64-bit gap subtract and window compares set the path from input register to result buffer.
// Reset: asynchronous, clears the tape state into PH_SYNC2 and leaves both enables low.
// Configuration writes take effect in the cycle after the beat.
// ----------------------------------------------------------------------------
module cassette_half_cycle_byte_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  chbd_event_if.sink        in_i,
  chbd_result_if.source     out_o,
  chbd_cfg_if.sink          cfg_i
);

  logic              push_valid, push_ready;
  chbd_pkg::result_t push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  chbd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_stamp_i   (in_i.cycle_stamp),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  chbd_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (out_o.valid),
    .pop_ready_i  (out_o.ready),
    .pop_data_o   (pop_data)
  );

  assign out_o.event_kind = pop_data.event_kind;
  assign out_o.data_byte  = pop_data.data_byte;

endmodule
`default_nettype wire

/* tb/sv/cassette_decode_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cassette_decode_monitor
// Watches the toggle, result and register channels of the cassette half-cycle
// byte decoder. Keeps its own copy of the tape state, predicts the rewind and
// byte beats that every accepted toggle causes, and checks each result beat
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module cassette_decode_monitor
  import chbd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  chbd_event_if  toggle_i,
  chbd_result_if result_i,
  chbd_cfg_if    cfg_i,
  output int     mismatches_o,
  output int     pending_o
);

  localparam int PrintCap = 40;

  logic              tape_loaded;
  logic              write_allowed;
  logic [StampW-1:0] last_stamp;
  phase_e            tape_phase;
  logic              first_toggle_pending;
  logic              half_toggle;
  logic [PosW-1:0]   bit_pos;
  logic [ByteW-1:0]  byte_acc;
  result_t           expected_beats[$];

  function automatic logic in_window(input logic [StampW-1:0] gap,
                                     input logic [CmpW-1:0] lo, input logic [CmpW-1:0] hi);
    return gap > StampW'(lo) && gap < StampW'(hi);
  endfunction

  task automatic report_mismatch(input string what, input logic [StampW-1:0] got,
                                 input logic [StampW-1:0] want);
    if (mismatches_o < PrintCap)
      $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
    mismatches_o++;
  endtask

  task automatic predict_toggle(input logic [StampW-1:0] stamp);
    logic [StampW-1:0] gap;
    logic              rewind;
    logic              byte_ready;
    logic [ByteW-1:0]  finished;
    logic              have_bit;
    logic              bit_val;
    result_t           beat;
    if (tape_loaded && write_allowed) begin
      rewind = first_toggle_pending;
      first_toggle_pending = 1'b0;
      byte_ready = 1'b0;
      finished = '0;
      bit_val = 1'b0;
      gap = stamp - last_stamp;
      last_stamp = stamp;
      if (in_window(gap, HdrLo, HdrHi)) begin
        tape_phase = PH_IDLE;
      end else if (tape_phase == PH_IDLE && in_window(gap, Sync1Lo, Sync1Hi)) begin
        tape_phase = PH_SYNC2;
      end else if (tape_phase == PH_SYNC2 && in_window(gap, ZeroLo, ZeroHi)) begin
        tape_phase = PH_DATA;
        half_toggle = 1'b1;
        bit_pos = '0;
        byte_acc = '0;
        rewind = 1'b1;
      end else if (tape_phase == PH_DATA) begin
        have_bit = 1'b1;
        if (in_window(gap, ZeroLo, ZeroHi)) bit_val = 1'b0;
        else if (in_window(gap, OneLo, OneHi)) bit_val = 1'b1;
        else have_bit = 1'b0;
        if (!have_bit) begin
          tape_phase = PH_IDLE;
        end else begin
          half_toggle = ~half_toggle;
          if (half_toggle) begin
            if (bit_val) byte_acc = byte_acc | (MsbMask >> bit_pos);
            bit_pos = bit_pos + 1'b1;
            if (bit_pos == '0) begin
              finished = byte_acc;
              byte_ready = 1'b1;
              byte_acc = '0;
            end
          end
        end
      end
      if (byte_ready) begin
        beat.event_kind = EV_BYTE;
        beat.data_byte = finished;
        expected_beats.push_back(beat);
      end else if (rewind) begin
        beat.event_kind = EV_REWIND;
        beat.data_byte = '0;
        expected_beats.push_back(beat);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_loaded = 1'b0;
      write_allowed = 1'b0;
      last_stamp = '0;
      tape_phase = PH_SYNC2;
      first_toggle_pending = 1'b1;
      half_toggle = 1'b0;
      bit_pos = '0;
      byte_acc = '0;
      expected_beats.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_TAPE_LOADED:   tape_loaded = cfg_i.data;
          CFG_WRITE_ALLOWED: write_allowed = cfg_i.data;
          default: ;
        endcase
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected result beat, kind/byte", result_i.event_kind,
                          result_i.data_byte);
        end else begin
          if (result_i.event_kind !== expected_beats[0].event_kind)
            report_mismatch("event_kind", result_i.event_kind, expected_beats[0].event_kind);
          if (result_i.data_byte !== expected_beats[0].data_byte)
            report_mismatch("data_byte", result_i.data_byte, expected_beats[0].data_byte);
          void'(expected_beats.pop_front());
        end
      end
      if (toggle_i.valid && toggle_i.ready) predict_toggle(toggle_i.cycle_stamp);
      pending_o = expected_beats.size();
    end
  end

endmodule

/* tb/sv/cassette_half_cycle_byte_decoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cassette_half_cycle_byte_decoder_test
// Drives stamped cassette toggles through the decoder: a directed pass over
// the gap windows and their edges, the enable combinations and stamp wrap,
// then random tape records with noise and broken records, under random
// sender bursts, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module cassette_half_cycle_byte_decoder_test;
  import chbd_pkg::*;

  localparam int LiveItems   = 1700;
  localparam int ChunkItems  = 300;
  localparam int SettleDelay = 6;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 500000;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic hold_off_armed = 1'b0;
  logic hold_off_done = 1'b0;
  int   mismatches;
  int   pending;
  int   cycle_count = 0;

  logic [StampW-1:0] tape_clock = '0;
  logic              tape_on = 1'b0;
  logic              write_on = 1'b0;
  int                live_items = 0;
  int                burst_left = 0;
  logic              paced = 1'b0;

  logic [CmpW-1:0] boundary_gaps [8] = '{HdrLo, HdrHi, Sync1Lo, Sync1Hi,
                                         ZeroLo, ZeroHi, OneLo, OneHi};

  chbd_event_if  toggle_ch ();
  chbd_result_if result_ch ();
  chbd_cfg_if    cfg_ch ();

  cassette_half_cycle_byte_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (toggle_ch),
    .out_o  (result_ch),
    .cfg_i  (cfg_ch)
  );

  cassette_decode_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .toggle_i     (toggle_ch),
    .result_i     (result_ch),
    .cfg_i        (cfg_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off
  initial begin
    rx_mode_e rx_mode;
    int       rx_left;
    int       rx_tick;
    result_ch.ready = 1'b0;
    rx_mode = RX_STEADY;
    rx_left = 0;
    rx_tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_armed && !hold_off_done) begin
        result_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off_done = 1'b1;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_STEADY:   result_ch.ready <= 1'b1;
        RX_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   result_ch.ready <= ($urandom_range(0, 7) != 0);
        default:     result_ch.ready <= ((rx_tick % 5) >= 3);
      endcase
    end
  end

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      toggle_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 60);
    end
  endtask

  task automatic offer_stamp(input logic [StampW-1:0] stamp);
    toggle_ch.valid <= 1'b1;
    toggle_ch.cycle_stamp <= stamp;
    @(posedge clk_i);
    while (!toggle_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (tape_on && write_on) live_items++;
    if (paced) pace_sender();
  endtask

  task automatic advance_tape(input logic [StampW-1:0] gap);
    tape_clock = tape_clock + gap;
    offer_stamp(tape_clock);
  endtask

  task automatic jump_tape(input logic [StampW-1:0] stamp);
    tape_clock = stamp;
    offer_stamp(tape_clock);
  endtask

  task automatic drain_decoder();
    toggle_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleDelay) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_TAPE_LOADED) tape_on = value;
    else write_on = value;
  endtask

  // toggles that the decoder should drop, stamps unrelated to the tape clock
  task automatic offer_ignored(input int count);
    repeat (count) offer_stamp({$urandom, $urandom});
  endtask

  function automatic logic [StampW-1:0] half_gap(input logic one);
    if (one) return StampW'($urandom_range(int'(OneHi) - 1, int'(OneLo) + 1));
    return StampW'($urandom_range(int'(ZeroHi) - 1, int'(ZeroLo) + 1));
  endfunction

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       advance_tape(StampW'(boundary_gaps[$urandom_range(0, 7)]));
      1:       advance_tape(StampW'($urandom_range(0, 1000)));
      default: jump_tape({$urandom, $urandom});
    endcase
  endtask

  task automatic send_record();
    int               headers;
    int               byte_count;
    logic [ByteW-1:0] value;
    headers = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    repeat (headers) advance_tape(StampW'($urandom_range(int'(HdrHi) - 1, int'(HdrLo) + 1)));
    if ($urandom_range(0, 9) == 0) send_noise();
    advance_tape(StampW'($urandom_range(int'(Sync1Hi) - 1, int'(Sync1Lo) + 1)));
    advance_tape(half_gap(1'b0));
    byte_count = $urandom_range(1, 4);
    repeat (byte_count) begin
      value = ByteW'($urandom);
      for (int i = ByteW - 1; i >= 0; i--) begin
        if ($urandom_range(0, 255) == 0) begin
          send_noise();
          return;
        end
        advance_tape(half_gap(1'($urandom_range(0, 1))));
        advance_tape(half_gap(value[i]));
      end
    end
    if ($urandom_range(0, 1)) send_noise();
  endtask

  initial begin
    logic [ByteW-1:0] pattern;
    cfg_reg_e         idx;
    int               chunk_goal;
    toggle_ch.valid = 1'b0;
    toggle_ch.cycle_stamp = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TAPE_LOADED;
    cfg_ch.data = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // both enables low after reset, then each alone
    offer_ignored(3);
    drain_decoder();
    write_register(CFG_TAPE_LOADED, 1'b1);
    offer_ignored(2);
    drain_decoder();
    write_register(CFG_TAPE_LOADED, 1'b0);
    write_register(CFG_WRITE_ALLOWED, 1'b1);
    offer_ignored(2);
    drain_decoder();
    write_register(CFG_TAPE_LOADED, 1'b1);

    // first toggle also opens a record: a single rewind
    advance_tape(StampW'(250));
    pattern = 8'h81;
    for (int i = 0; i < ByteW; i++) begin
      advance_tape(i[0] ? StampW'(504) : StampW'(246));
      if (pattern[ByteW - 1 - i]) advance_tape(i[1] ? StampW'(496) : StampW'(504));
      else advance_tape(i[1] ? StampW'(246) : StampW'(254));
    end
    advance_tape(StampW'(505));
    advance_tape(StampW'(660));
    advance_tape(StampW'(651));
    advance_tape(StampW'(210));
    advance_tape(StampW'(191));
    advance_tape(StampW'(255));
    advance_tape(StampW'(254));
    advance_tape(StampW'(496));
    advance_tape(StampW'(659));
    advance_tape(StampW'(190));
    advance_tape(StampW'(209));
    advance_tape(StampW'(246));
    advance_tape(StampW'(495));
    jump_tape('1);
    advance_tape(StampW'(655));
    drain_decoder();

    // random records with sender and receiver idling
    paced = 1'b1;
    hold_off_armed = 1'b1;
    chunk_goal = live_items + ChunkItems;
    while (live_items < LiveItems) begin
      if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 5)) send_noise();
      else send_record();
      if (live_items >= chunk_goal) begin
        chunk_goal = live_items + ChunkItems;
        drain_decoder();
        idx = cfg_reg_e'($urandom_range(0, 1));
        write_register(idx, 1'b0);
        if ($urandom_range(0, 2) == 0)
          write_register(idx == CFG_TAPE_LOADED ? CFG_WRITE_ALLOWED : CFG_TAPE_LOADED, 1'b0);
        offer_ignored($urandom_range(5, 25));
        drain_decoder();
        write_register(CFG_TAPE_LOADED, 1'b1);
        write_register(CFG_WRITE_ALLOWED, 1'b1);
      end
    end

    drain_decoder();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* cassette_half_cycle_byte_decoder.f */
src/chbd_pkg.sv
src/chbd_if.sv
src/chbd_core.sv
src/chbd_out_buf.sv
src/cassette_half_cycle_byte_decoder.sv
tb/sv/cassette_decode_monitor.sv
tb/sv/cassette_half_cycle_byte_decoder_test.sv
